### hdl/assert_macros.svh
// Assertion helpers shared by the top-level unit and cfbc_cfg.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same, on the house clock and reset.
`define ASSERT_STD(label, prop, msg) `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

### hdl/cfbc_pkg.sv
package cfbc_pkg;

    localparam int MAX_BLOCK_DEF = 32;
    localparam int MAX_KEY_DEF   = 64;

    localparam int BLK_W     = 6;   // block_length register
    localparam int KLEN_W    = 7;   // key_length register
    localparam int KEY_W     = 64;  // key_bits register
    localparam int POS_W     = 7;   // position count and padded length
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_LENGTH = 2'd0,
        CFG_KEY_LENGTH   = 2'd1,
        CFG_KEY_BITS     = 2'd2,
        CFG_DIRECTION    = 2'd3
    } t_cfg_idx;

    // Configuration as seen by the key stream logic.
    typedef struct packed {
        logic [BLK_W-1:0]  block_length;
        logic [KLEN_W-1:0] key_length;
        logic [KEY_W-1:0]  key_bits;
        logic              direction;
        logic [POS_W-1:0]  padded;   // key length rounded up to a block multiple
        logic              err;      // unusable configuration
        logic              busy;     // padded length being recomputed
    } t_cfg;

endpackage

### hdl/ciphertext_feedback_bit_cipher_unit.sv
// Items pass through the input register, then the result register.
// Throughput: one item per cycle while results drain and no config write or padding
// calc is in progress; key bit, parity and history update are combinational. A config
// write stalls input while repeated adds of block_length rebuild the padded key length.
// Reset (i_rst_n low, synchronous) loads the default config, clears all history
// and runs that same padding calc before the first item is taken.
`include "assert_macros.svh"

module ciphertext_feedback_bit_cipher_unit #(
    parameter int MAX_BLOCK = cfbc_pkg::MAX_BLOCK_DEF,  // 1..63
    parameter int MAX_KEY   = cfbc_pkg::MAX_KEY_DEF     // 2..64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cfbc_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [0] data_bit, rest zero
    input  logic                             s_axis_tuser,   // [0] restart
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [cfbc_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [0] out_bit, [1] key_bit,
                                                             // [2] config_error, rest zero
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cfbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cfbc_pkg::KEY_W-1:0]       i_cfg_data
);
    import cfbc_pkg::*;

    t_cfg w_cfg;

    // Input register
    logic r_in_valid;
    logic r_in_data;
    logic r_in_restart;

    // Result register
    logic r_out_valid;
    logic r_out_bit;
    logic r_key_bit;
    logic r_cfg_err;

    logic w_out_free;
    logic w_advance;
    logic w_in_accept;
    logic w_out_bit;
    logic w_key_bit;
    logic w_config_error;

    // Config writes are always taken; each one restarts the padding calc.
    assign o_cfg_ready = 1'b1;

    cfbc_cfg #(
        .MAX_BLOCK (MAX_BLOCK),
        .MAX_KEY   (MAX_KEY)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // The item in the input register moves on whenever the result register
    // is empty or being drained this cycle.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = (!r_in_valid || w_advance) && !w_cfg.busy && !i_cfg_valid;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_data    <= s_axis_tdata[0];
            r_in_restart <= s_axis_tuser;
        end
    end

    // Key stream and history; state steps when the item advances.
    cfbc_keygen #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_keygen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_advance      (w_advance),
        .i_data_bit     (r_in_data),
        .i_restart      (r_in_restart),
        .o_out_bit      (w_out_bit),
        .o_key_bit      (w_key_bit),
        .o_config_error (w_config_error)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_bit <= w_out_bit;
            r_key_bit <= w_key_bit;
            r_cfg_err <= w_config_error;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-3){1'b0}}, r_cfg_err, r_key_bit, r_out_bit};

    `ASSERT_STD(a_err_zeroes, m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'b00, "config error result carries nonzero bits")
    `ASSERT_STD(a_full_stall, r_in_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while pipeline is full and stalled")
    `ASSERT_STD(a_out_source, $rose(m_axis_tvalid) |-> $past(r_in_valid), "result appeared without an item in the input register")

endmodule

### hdl/cfbc_cfg.sv
`include "assert_macros.svh"

module cfbc_cfg #(
    parameter int MAX_BLOCK = cfbc_pkg::MAX_BLOCK_DEF,
    parameter int MAX_KEY   = cfbc_pkg::MAX_KEY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [cfbc_pkg::CFG_IDX_W-1:0]       i_wr_index,
    input  logic [cfbc_pkg::KEY_W-1:0]           i_wr_data,
    output cfbc_pkg::t_cfg                       o_cfg
);
    import cfbc_pkg::*;

    logic [BLK_W-1:0]  r_block_length;
    logic [KLEN_W-1:0] r_key_length;
    logic [KEY_W-1:0]  r_key_bits;
    logic              r_direction;
    logic              r_busy,   n_busy;
    logic [POS_W-1:0]  r_acc,    n_acc;
    logic [POS_W-1:0]  r_padded, n_padded;
    logic              w_err;

    assign w_err = (r_block_length == '0)
                || (r_block_length > BLK_W'(MAX_BLOCK))
                || (r_key_length > KLEN_W'(MAX_KEY))
                || (r_key_length <= KLEN_W'(r_block_length));

    // Padded length: add k until the key length is covered, one add per cycle; an unusable config stops it.
    always_comb begin
        n_busy   = r_busy;
        n_acc    = r_acc;
        n_padded = r_padded;
        if (i_wr_en) begin
            n_busy = 1'b1;
            n_acc  = '0;
        end else if (r_busy) begin
            if (w_err) begin
                n_busy = 1'b0;
            end else if (r_acc < POS_W'(r_key_length)) begin
                n_acc = r_acc + POS_W'(r_block_length);
            end else begin
                n_padded = r_acc;
                n_busy   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLK_W'(1);
            r_key_length   <= KLEN_W'(2);
            r_key_bits     <= '0;
            r_direction    <= 1'b0;
            r_busy         <= 1'b1;
            r_acc          <= '0;
            r_padded       <= '0;
        end else begin
            r_busy   <= n_busy;
            r_acc    <= n_acc;
            r_padded <= n_padded;
            if (i_wr_en) begin
                case (t_cfg_idx'(i_wr_index))
                    CFG_BLOCK_LENGTH: r_block_length <= i_wr_data[BLK_W-1:0];
                    CFG_KEY_LENGTH:   r_key_length   <= i_wr_data[KLEN_W-1:0];
                    CFG_KEY_BITS:     r_key_bits     <= i_wr_data;
                    CFG_DIRECTION:    r_direction    <= i_wr_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_cfg.block_length = r_block_length;
    assign o_cfg.key_length   = r_key_length;
    assign o_cfg.key_bits     = r_key_bits;
    assign o_cfg.direction    = r_direction;
    assign o_cfg.padded       = r_padded;
    assign o_cfg.err          = w_err;
    assign o_cfg.busy         = r_busy;

    `ASSERT_STD(a_wr_sets_busy, i_wr_en |=> r_busy, "config write did not start padding calc")
    `ASSERT_STD(a_acc_bound, r_busy && !w_err |-> 8'(r_acc) < 8'(r_key_length) + 8'(r_block_length), "padding accumulator overran")
    `ASSERT_STD(a_pad_range, $fell(r_busy) && !w_err |-> (r_padded >= POS_W'(r_key_length)) && (8'(r_padded) < 8'(r_key_length) + 8'(r_block_length)), "padded length out of range")

endmodule

### hdl/cfbc_keygen.sv
module cfbc_keygen #(
    parameter int MAX_BLOCK = cfbc_pkg::MAX_BLOCK_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cfbc_pkg::t_cfg i_cfg,
    input  logic           i_advance,
    input  logic           i_data_bit,
    input  logic           i_restart,
    output logic           o_out_bit,
    output logic           o_key_bit,
    output logic           o_config_error
);
    import cfbc_pkg::*;

    localparam int KH_W  = MAX_BLOCK + 1;
    localparam int CH_W  = MAX_BLOCK;
    localparam int KI_W  = $clog2(KH_W);
    localparam int PH_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int KB_IW = $clog2(KEY_W);

    logic [KH_W-1:0]  r_key_hist,    n_key_hist;
    logic [CH_W-1:0]  r_cipher_hist, n_cipher_hist;
    logic [POS_W-1:0] r_pos,         n_pos;
    logic [PH_W-1:0]  r_phase,       n_phase;

    logic [KH_W-1:0]  w_kh;
    logic [CH_W-1:0]  w_ch;
    logic [POS_W-1:0] w_pos;
    logic [PH_W-1:0]  w_ph;
    logic [PH_W-1:0]  w_ph0;
    logic [CH_W-1:0]  w_par_bits;
    logic [KI_W-1:0]  w_k_idx;
    logic             w_in_key;
    logic             w_in_pad;
    logic             w_parity;
    logic             w_kb;
    logic             w_ob;
    logic             w_cb;

    // Restart clears history before the current bit is used.
    assign w_kh  = i_restart ? '0 : r_key_hist;
    assign w_ch  = i_restart ? '0 : r_cipher_hist;
    assign w_pos = i_restart ? '0 : r_pos;
    assign w_ph  = i_restart ? '0 : r_phase;

    assign w_k_idx  = KI_W'(i_cfg.block_length);
    assign w_in_key = w_pos < POS_W'(i_cfg.key_length);
    assign w_in_pad = w_pos < i_cfg.padded;
    assign w_ph0    = (POS_W'(w_ph) >= POS_W'(i_cfg.block_length)) ? '0 : w_ph;

    always_comb begin
        for (int i = 0; i < CH_W; i++) begin
            w_par_bits[i] = w_ch[i] & (POS_W'(i) < POS_W'(i_cfg.block_length));
        end
    end
    assign w_parity = ^w_par_bits;

    always_comb begin
        if (w_in_key) begin
            w_kb = i_cfg.key_bits[w_pos[KB_IW-1:0]];
        end else if (w_in_pad || (w_ph0 != '0)) begin
            w_kb = w_kh[w_k_idx];
        end else begin
            w_kb = w_parity;
        end
    end

    assign w_ob = i_data_bit ^ w_kb;
    assign w_cb = i_cfg.direction ? i_data_bit : w_ob;

    always_comb begin
        n_key_hist    = w_kh;
        n_cipher_hist = w_ch;
        n_pos         = w_pos;
        n_phase       = w_ph;
        if (!i_cfg.err) begin
            n_key_hist    = KH_W'({w_kh, w_kb});
            n_cipher_hist = CH_W'({w_ch, w_cb});
            if (w_in_pad) begin
                n_pos   = w_pos + POS_W'(1);
                n_phase = '0;
            end else if (POS_W'(w_ph0) + POS_W'(1) >= POS_W'(i_cfg.block_length)) begin
                n_phase = '0;
            end else begin
                n_phase = w_ph0 + PH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hist    <= '0;
            r_cipher_hist <= '0;
            r_pos         <= '0;
            r_phase       <= '0;
        end else if (i_advance) begin
            r_key_hist    <= n_key_hist;
            r_cipher_hist <= n_cipher_hist;
            r_pos         <= n_pos;
            r_phase       <= n_phase;
        end
    end

    assign o_out_bit      = i_cfg.err ? 1'b0 : w_ob;
    assign o_key_bit      = i_cfg.err ? 1'b0 : w_kb;
    assign o_config_error = i_cfg.err;

endmodule

### bench/cfbc_keystream_checker.sv
`timescale 1ns / 1ps

// Watches the config, input and result channels of the cipher unit.
// Keeps its own copy of config and key-stream state, predicts one result per
// accepted input item and compares results in order.
module cfbc_keystream_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [cfbc_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [cfbc_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [cfbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cfbc_pkg::KEY_W-1:0]      i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import cfbc_pkg::*;

    localparam int MAX_BLK  = MAX_BLOCK_DEF;
    localparam int MAX_KLEN = MAX_KEY_DEF;

    typedef struct packed {
        logic out_bit;
        logic key_bit;
        logic config_error;
    } t_bit_result;

    // config copy
    logic [BLK_W-1:0]  blk_len;
    logic [KLEN_W-1:0] key_len;
    logic [KEY_W-1:0]  key_init;
    logic              decrypt;

    // key-stream state
    logic [32:0]       key_hist;    // bit i = key bit from i+1 items ago
    logic [31:0]       ctext_hist;  // newest ciphertext bit in bit 0
    logic [POS_W-1:0]  bit_pos;
    logic [4:0]        blk_phase;

    t_bit_result       expected_bits[$];

    task automatic clear_stream();
        key_hist   = '0;
        ctext_hist = '0;
        bit_pos    = '0;
        blk_phase  = '0;
    endtask

    task automatic cipher_step(input logic d, input logic restart, output t_bit_result res);
        int          k;
        int          len;
        int          padded;
        int          pos;
        logic        kb;
        logic        cb;
        logic [63:0] window;
        if (restart)
            clear_stream();
        k   = int'(blk_len);
        len = int'(key_len);
        if (k == 0 || k > MAX_BLK || len > MAX_KLEN || len <= k) begin
            // unusable config: zeros out, state frozen
            res.out_bit      = 1'b0;
            res.key_bit      = 1'b0;
            res.config_error = 1'b1;
        end else begin
            padded = ((len + k - 1) / k) * k;
            pos    = int'(bit_pos);
            if (pos < len) begin
                kb = key_init[pos];
            end else if (pos < padded) begin
                kb = key_hist[k];
            end else begin
                if (int'(blk_phase) >= k)
                    blk_phase = '0;
                if (blk_phase == 5'd0) begin
                    // parity over the last k ciphertext bits
                    window = {32'b0, ctext_hist} & ((64'd1 << k) - 64'd1);
                    kb = ^window;
                end else begin
                    kb = key_hist[k];
                end
            end
            cb         = decrypt ? d : (d ^ kb);
            key_hist   = {key_hist[31:0], kb};
            ctext_hist = {ctext_hist[30:0], cb};
            if (pos < padded) begin
                bit_pos   = POS_W'(pos + 1);
                blk_phase = '0;
            end else begin
                blk_phase = (int'(blk_phase) + 1 >= k) ? 5'd0 : 5'(int'(blk_phase) + 1);
            end
            res.out_bit      = d ^ kb;
            res.key_bit      = kb;
            res.config_error = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_bit_result want;
        t_bit_result got;
        if (!i_rst_n) begin
            blk_len  = BLK_W'(1);
            key_len  = KLEN_W'(2);
            key_init = '0;
            decrypt  = 1'b0;
            clear_stream();
            expected_bits.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BLOCK_LENGTH: blk_len  = i_cfg_data[BLK_W-1:0];
                    CFG_KEY_LENGTH:   key_len  = i_cfg_data[KLEN_W-1:0];
                    CFG_KEY_BITS:     key_init = i_cfg_data;
                    CFG_DIRECTION:    decrypt  = i_cfg_data[0];
                    default: ;
                endcase
            end
            // results first: a result never belongs to an item taken this edge
            if (i_m_tvalid && i_m_tready) begin
                got.out_bit      = i_m_tdata[0];
                got.key_bit      = i_m_tdata[1];
                got.config_error = i_m_tdata[2];
                if (expected_bits.size() == 0) begin
                    $error("result item with nothing outstanding: tdata %h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_bits.pop_front();
                    if (got != want) begin
                        if (got.out_bit != want.out_bit)
                            $error("out_bit: expected %0b, actual %0b",
                                   want.out_bit, got.out_bit);
                        if (got.key_bit != want.key_bit)
                            $error("key_bit: expected %0b, actual %0b",
                                   want.key_bit, got.key_bit);
                        if (got.config_error != want.config_error)
                            $error("config_error: expected %0b, actual %0b",
                                   want.config_error, got.config_error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                cipher_step(i_s_tdata[0], i_s_tuser, want);
                expected_bits.push_back(want);
            end
            o_pending <= expected_bits.size();
        end
    end

endmodule

### bench/ciphertext_feedback_bit_cipher_unit_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the ciphertext-feedback bit cipher unit.
// Checking lives in cfbc_keystream_checker; this module only drives the
// channels, shapes the stalls and prints the result.
module ciphertext_feedback_bit_cipher_unit_test;
    import cfbc_pkg::*;

    localparam int RANDOM_ITEMS = 1250;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // [0] data_bit, rest zero
    logic                  s_axis_tuser;   // [0] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // [0] out_bit, [1] key_bit, [2] config_error
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [KEY_W-1:0]      i_cfg_data;

    int          fail_count;
    int          pending;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned settings_used;

    ciphertext_feedback_bit_cipher_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    cfbc_keystream_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit: far above the slowest legal run (config stalls, 46% gaps).
    initial begin
        #1_000_000;
        $display("FAIL ciphertext_feedback_bit_cipher_unit");
        $finish;
    end

    // Result side: random back-pressure at the current stall rate.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One input item; valid stays high into the next call unless a gap is drawn.
    task automatic send_item(input logic d, input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, d};
        s_axis_tuser  <= restart;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [KEY_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // New setting: only once the unit is idle.
    task automatic apply_setting(input logic [BLK_W-1:0] k, input logic [KLEN_W-1:0] len,
                                 input logic [KEY_W-1:0] key, input logic dir);
        drain_results();
        write_reg(CFG_BLOCK_LENGTH, KEY_W'(k));
        write_reg(CFG_KEY_LENGTH, KEY_W'(len));
        write_reg(CFG_KEY_BITS, key);
        write_reg(CFG_DIRECTION, KEY_W'(dir));
        settings_used++;
    endtask

    // Mostly legal settings with the extremes weighted up; a few unusable ones.
    task automatic pick_setting();
        logic [BLK_W-1:0]  k;
        logic [KLEN_W-1:0] len;
        logic [KEY_W-1:0]  key;
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(3))
                0: begin
                    k   = '0;
                    len = KLEN_W'($urandom_range(2, 64));
                end
                1: begin
                    k   = BLK_W'($urandom_range(33, 63));
                    len = KLEN_W'(64);
                end
                2: begin
                    k   = BLK_W'($urandom_range(1, 32));
                    len = KLEN_W'($urandom_range(0, int'(k)));   // key not longer than block
                end
                default: begin
                    k   = BLK_W'($urandom_range(1, 32));
                    len = KLEN_W'($urandom_range(65, 127));
                end
            endcase
        end else begin
            case ($urandom_range(3))
                0:       k = BLK_W'(1);
                1:       k = BLK_W'(32);
                default: k = BLK_W'($urandom_range(2, 8));
            endcase
            case ($urandom_range(2))
                0:       len = KLEN_W'(int'(k) + 1);
                1:       len = KLEN_W'(64);
                default: len = KLEN_W'($urandom_range(int'(k) + 1, 64));
            endcase
        end
        case ($urandom_range(3))
            0:       key = '0;
            1:       key = '1;
            default: key = {$urandom(), $urandom()};
        endcase
        apply_setting(k, len, key, 1'($urandom_range(1)));
    endtask

    initial begin
        int unsigned rand_base;
        int unsigned done;
        int          msg_len;
        logic        first_restart;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_BLOCK_LENGTH;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent    = 0;
        settings_used = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset config first (k=1, L=2, zero key)
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b0);
        // key length equal to block length is unusable; restart still clears
        apply_setting(BLK_W'(2), KLEN_W'(2), '1, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        // zero block length
        apply_setting(BLK_W'(0), KLEN_W'(5), '1, 1'b1);
        send_item(1'b1, 1'b0);
        // k=3, L=4: key bits, two padding bits, then parity blocks
        apply_setting(BLK_W'(3), KLEN_W'(4), 64'hB, 1'b0);
        send_item(1'b1, 1'b1);
        for (int i = 0; i < 11; i++)
            send_item(1'($urandom_range(1)), 1'b0);
        // flip to decrypt mid-message, no restart
        apply_setting(BLK_W'(3), KLEN_W'(4), 64'hB, 1'b1);
        for (int i = 0; i < 5; i++)
            send_item(1'($urandom_range(1)), 1'b0);

        // Random messages under random settings; drains between settings
        rand_base = items_sent;
        while (items_sent < rand_base + RANDOM_ITEMS) begin
            done = items_sent - rand_base;
            if (done < RANDOM_ITEMS / 3) begin
                send_idle_pct = 24;
                recv_idle_pct = 46;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 46;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick_setting();
            repeat ($urandom_range(1, 2)) begin
                msg_len = $urandom_range(8, 130);
                // most messages open with a restart; the rest carry on mid-stream
                first_restart = ($urandom_range(9) != 0);
                for (int i = 0; i < msg_len; i++)
                    send_item(1'($urandom_range(1)),
                              (i == 0) ? first_restart : ($urandom_range(99) < 2));
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d items over %0d settings: key, padding and parity phases,",
                 items_sent, settings_used);
        $display("restarts, bad configs, mid-message changes, both stall mixes and no stalls");
        if (fail_count == 0 && pending == 0)
            $display("PASS ciphertext_feedback_bit_cipher_unit");
        else
            $display("FAIL ciphertext_feedback_bit_cipher_unit");
        $finish;
    end

endmodule
